@@ src/mcgbm_pkg.sv @@
// Shared types, constants and limits for the GBM call pricer.
`default_nettype none
package mcgbm_pkg;
  localparam int unsigned MAX_STEPS_DEF = 4096;
  localparam longint unsigned MAX_PATHS_DEF = 64'd268435455;

  localparam logic [2:0] REG_STEPS = 3'd0;
  localparam logic [2:0] REG_PATHS = 3'd1;
  localparam logic [2:0] REG_DRIFT = 3'd2;
  localparam logic [2:0] REG_DIFF  = 3'd3;
  localparam logic [2:0] REG_SPOT  = 3'd4;
  localparam logic [2:0] REG_STRIKE = 3'd5;
  localparam logic [2:0] REG_DISC  = 3'd6;

  localparam logic signed [47:0] LOG_SUM_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] LOG_SUM_MIN = 48'sh8000_0000_0000;
  localparam logic [63:0] LN2_Q58 = (64'hB17217F7D1CF79AB >> 6) + 64'd1;

  // Configuration as seen by the back end.
  typedef struct packed {
    logic [31:0] spot;
    logic [31:0] strike;
    logic [31:0] disc;
    logic [27:0] paths;
  } cfg_t;

  // Word handed from the front end to the back end at the end of a path.
  typedef struct packed {
    logic signed [47:0] log_sum;
    logic               sat;
  } path_t;
endpackage
`default_nettype wire

@@ src/monte_carlo_gbm_call_pricer.sv @@
// Top level of the Monte Carlo GBM European call pricer.
// For a finished path the back end skips exp when it saturates or underflows;
// else it reduces the argument by repeated subtraction and sums up to 24 series
// terms. Throughput: one sample per cycle while the path queue has room; the
// back end sets the path rate, and the final discounted average ends each batch.
// Reset: synchronous active-low rst_n clears the sums, counters and control
// state and loads the default configuration.
`default_nettype none
module monte_carlo_gbm_call_pricer #(
  parameter int unsigned     MAX_STEPS = mcgbm_pkg::MAX_STEPS_DEF,
  parameter longint unsigned MAX_PATHS = mcgbm_pkg::MAX_PATHS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic signed [15:0] in_z_sample,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output logic [31:0]             out_option_price,
  output logic                    out_saturated_flag,
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [4:0]         cfg_paddr,
  input  wire logic [31:0]        cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);
  import mcgbm_pkg::*;

  logic [12:0] steps_r;
  logic [27:0] paths_r;
  logic signed [31:0] drift_r;
  logic [30:0] diff_r;
  logic [31:0] spot_r, strike_r, disc_r;
  logic        wr_en;
  logic [2:0]  ridx;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;
  assign ridx = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r <= 13'd100;
      paths_r <= 28'd100000;
      drift_r <= 32'sd161061;
      diff_r <= 31'd10737418;
      spot_r <= 32'd6553600;
      strike_r <= 32'd6881280;
      disc_r <= 32'd2042749625;
    end else if (wr_en) begin
      case (ridx)
        REG_STEPS: steps_r <= cfg_pwdata[12:0];
        REG_PATHS: paths_r <= cfg_pwdata[27:0];
        REG_DRIFT: drift_r <= cfg_pwdata;
        REG_DIFF: diff_r <= cfg_pwdata[30:0];
        REG_SPOT: spot_r <= cfg_pwdata;
        REG_STRIKE: strike_r <= cfg_pwdata;
        REG_DISC: disc_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_STEPS: cfg_prdata = 32'(steps_r);
      REG_PATHS: cfg_prdata = 32'(paths_r);
      REG_DRIFT: cfg_prdata = drift_r;
      REG_DIFF: cfg_prdata = 32'(diff_r);
      REG_SPOT: cfg_prdata = spot_r;
      REG_STRIKE: cfg_prdata = strike_r;
      REG_DISC: cfg_prdata = disc_r;
      default: cfg_prdata = 32'd0;
    endcase
  end

  logic   take, pv, q_full, q_empty, q_pop, res_v, busy;
  path_t  pw, qw;
  cfg_t   bcfg;

  assign in_full = q_full;
  assign take = in_push && !q_full;
  assign bcfg = '{spot: spot_r, strike: strike_r, disc: disc_r, paths: paths_r};

  mcgbm_front #(.MAX_STEPS(MAX_STEPS)) u_front (
    .clk(clk), .rst_n(rst_n), .take(take), .z(in_z_sample), .drift(drift_r),
    .diffusion(diff_r), .steps(steps_r), .path_valid(pv), .path_word(pw)
  );

  mcgbm_fifo #(.DEPTH(4)) u_fifo (
    .clk(clk), .rst_n(rst_n), .wr(pv), .wdata(pw), .full(q_full),
    .rd(q_pop), .empty(q_empty), .rdata(qw)
  );

  mcgbm_back #(.MAX_PATHS(MAX_PATHS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_word(qw), .q_pop(q_pop),
    .cfg(bcfg), .res_valid(res_v), .res_pop(out_pop), .res_price(out_option_price),
    .res_sat(out_saturated_flag), .busy(busy)
  );

  assign out_empty = !res_v;

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !take) else $error("sample taken while queue full");
  a_pop_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty) else $error("result lost");
  a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> busy) else $error("result shown while idle");
endmodule
`default_nettype wire

@@ src/mcgbm_front.sv @@
// Front end: accumulates log increments of one path and hands finished paths on.
`default_nettype none
module mcgbm_front #(
  parameter int unsigned MAX_STEPS = mcgbm_pkg::MAX_STEPS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  take,
  input  wire logic signed [15:0]    z,
  input  wire logic signed [31:0]    drift,
  input  wire logic [30:0]           diffusion,
  input  wire logic [12:0]           steps,
  output logic                       path_valid,
  output mcgbm_pkg::path_t           path_word
);
  import mcgbm_pkg::*;
  localparam int CW = $clog2(MAX_STEPS + 1);

  logic signed [47:0] sum_r, sum_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               sat_r, sat_nxt;
  logic signed [47:0] prod;
  logic signed [49:0] wide;
  logic               sat_step;
  logic [CW-1:0]      eff;
  logic [CW-1:0]      cnt_inc;

  always_comb begin
    prod = (48'($signed({1'b0, diffusion})) * 48'(z)) >>> 12;
    wide = 50'(sum_r) + 50'(drift) + 50'(prod);
    sat_step = 1'b0;
    if (wide > 50'(LOG_SUM_MAX)) begin
      sum_nxt = LOG_SUM_MAX;
      sat_step = 1'b1;
    end else if (wide < 50'(LOG_SUM_MIN)) begin
      sum_nxt = LOG_SUM_MIN;
      sat_step = 1'b1;
    end else begin
      sum_nxt = wide[47:0];
    end
    if (steps == 13'd0) begin
      eff = CW'(1);
    end else if (32'(steps) > MAX_STEPS) begin
      eff = CW'(MAX_STEPS);
    end else begin
      eff = CW'(steps);
    end
    cnt_inc = cnt_r + CW'(1);
    path_valid = take && (cnt_inc >= eff);
    path_word.log_sum = sum_nxt;
    path_word.sat = sat_r | sat_step;
    cnt_nxt = path_valid ? '0 : cnt_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
      sat_r <= 1'b0;
    end else if (take) begin
      sum_r <= path_valid ? '0 : sum_nxt;
      cnt_r <= cnt_nxt;
      sat_r <= path_valid ? 1'b0 : sat_r | sat_step;
    end
  end
endmodule
`default_nettype wire

@@ src/mcgbm_fifo.sv @@
// Short queue of finished paths between the front and the back end.
`default_nettype none
module mcgbm_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr,
  input  wire mcgbm_pkg::path_t wdata,
  output logic                  full,
  input  wire logic             rd,
  output logic                  empty,
  output mcgbm_pkg::path_t      rdata
);
  import mcgbm_pkg::*;
  localparam int AW = $clog2(DEPTH);
  path_t            mem_r [DEPTH];
  logic [AW-1:0]    wp_r, rp_r;
  logic [AW:0]      cnt_r;

  assign full = (cnt_r == (AW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr && !full) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr && !full) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
      if (rd && !empty) rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
      cnt_r <= cnt_r + (AW+1)'(wr && !full) - (AW+1)'(rd && !empty);
    end
  end
endmodule
`default_nettype wire

@@ src/mcgbm_back.sv @@
// Back end: exp, payoff accumulation and the final discounted average.
`default_nettype none
module mcgbm_back #(
  parameter longint unsigned MAX_PATHS = mcgbm_pkg::MAX_PATHS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_empty,
  input  wire mcgbm_pkg::path_t q_word,
  output logic                  q_pop,
  input  wire mcgbm_pkg::cfg_t  cfg,
  output logic                  res_valid,
  input  wire logic             res_pop,
  output logic [31:0]           res_price,
  output logic                  res_sat,
  output logic                  busy
);
  import mcgbm_pkg::*;
  localparam int PW = $clog2(MAX_PATHS + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RED  = 4'd1;
  localparam logic [3:0] S_SER  = 4'd2;
  localparam logic [3:0] S_DIVN = 4'd3;
  localparam logic [3:0] S_SCAL = 4'd4;
  localparam logic [3:0] S_PM0  = 4'd5;
  localparam logic [3:0] S_PRC  = 4'd6;
  localparam logic [3:0] S_M0   = 4'd7;
  localparam logic [3:0] S_M1   = 4'd8;
  localparam logic [3:0] S_DIV  = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;
  localparam logic [3:0] S_PAY  = 4'd11;
  localparam logic [3:0] S_FMUL = 4'd12;
  localparam logic [3:0] S_FNUM = 4'd13;

  logic [3:0]   st_r;
  logic [PW-1:0] pcnt_r;
  logic [63:0]  psum_r;
  logic         sat_r;
  logic signed [47:0] l_r;
  logic [63:0]  x_r, k_r, r62_r, term_r, sum_r, tmp_r;
  logic [4:0]   n_r;
  logic [6:0]   i_r;
  logic [127:0] num_r;
  logic [63:0]  rem_r, q_r;
  logic         big_r;
  logic [31:0]  price_out_r;
  logic         out_v_r, out_sat_r;
  logic [PW-1:0] effp;

  // 64x64 product in four 32x32 pieces over cycles.
  logic [1:0]   pp_r;
  logic [63:0]  ma_r, mb_r;
  logic [127:0] acc_r;
  logic [63:0]  pprod;

  always_comb begin
    if (cfg.paths == 28'd0) begin
      effp = PW'(1);
    end else if (64'(cfg.paths) > MAX_PATHS) begin
      effp = PW'(MAX_PATHS);
    end else begin
      effp = PW'(cfg.paths);
    end
    case (pp_r)
      2'd0: pprod = ma_r[31:0] * mb_r[31:0];
      2'd1: pprod = ma_r[31:0] * mb_r[63:32];
      2'd2: pprod = ma_r[63:32] * mb_r[31:0];
      default: pprod = ma_r[63:32] * mb_r[63:32];
    endcase
  end

  assign q_pop = (st_r == S_IDLE) && !q_empty;
  assign res_valid = out_v_r;
  assign res_price = price_out_r;
  assign res_sat = out_sat_r;
  assign busy = (st_r != S_IDLE) || out_v_r;

  logic [63:0] d_w;
  logic [64:0] rem_sh;
  logic [63:0] q_sh;
  logic [6:0]  shamt;
  logic [63:0] ex_w;
  logic [64:0] ps_add;
  logic [63:0] pay_w;
  logic [127:0] nm_add;
  always_comb begin
    d_w = 64'(effp) << 31;
    rem_sh = {rem_r, num_r[127]};
    q_sh = {q_r[62:0], 1'b0};
    shamt = 7'd46 - 7'(k_r);
    ex_w = (sum_r + (64'd1 << (shamt - 7'd1))) >> shamt;
    pay_w = (tmp_r > 64'(cfg.strike)) ? tmp_r - 64'(cfg.strike) : 64'd0;
    ps_add = 65'(psum_r) + 65'(pay_w);
    nm_add = acc_r + 128'(d_w >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      pcnt_r <= '0;
      psum_r <= '0;
      sat_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (res_pop && out_v_r) out_v_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (!q_empty) begin
            l_r <= q_word.log_sum;
            sat_r <= sat_r | q_word.sat;
            st_r <= S_RED;
          end
        end
        S_RED: begin
          if (l_r > 48'sd6442450944) begin
            sat_r <= 1'b1;
            tmp_r <= 64'd0;
            ma_r <= 64'(cfg.spot);
            mb_r <= 64'hFFFF_FFFF;
            pp_r <= 2'd0;
            acc_r <= '0;
            st_r <= S_PM0;
          end else if (l_r < -48'sd6979321856) begin
            ma_r <= 64'(cfg.spot);
            mb_r <= 64'd0;
            pp_r <= 2'd0;
            acc_r <= '0;
            st_r <= S_PM0;
          end else begin
            // Reduction: x = L*2^29, k = floor(x/ln2) by repeated subtraction.
            x_r <= 64'(l_r) <<< 29;
            rem_r <= (l_r < 0) ? -(64'(l_r) <<< 29) : (64'(l_r) <<< 29);
            q_r <= '0;
            st_r <= S_DIVN;
          end
        end
        S_DIVN: begin
          // The quotient is below twenty, so one subtraction per cycle is enough.
          if (rem_r >= LN2_Q58) begin
            rem_r <= rem_r - LN2_Q58;
            q_r <= q_r + 64'd1;
          end else begin
            st_r <= S_SCAL;
          end
        end
        S_SCAL: begin
          if ($signed(x_r) < 0) begin
            if (rem_r != 64'd0) begin
              k_r <= -q_r - 64'd1;
              r62_r <= (LN2_Q58 - rem_r) << 4;
              mb_r <= (LN2_Q58 - rem_r) << 4;
            end else begin
              k_r <= -q_r;
              r62_r <= 64'd0;
              mb_r <= 64'd0;
            end
          end else begin
            k_r <= q_r;
            r62_r <= rem_r << 4;
            mb_r <= rem_r << 4;
          end
          term_r <= 64'd1 << 62;
          sum_r <= 64'd1 << 62;
          n_r <= 5'd1;
          ma_r <= 64'd1 << 62;
          pp_r <= 2'd0;
          acc_r <= '0;
          st_r <= S_SER;
        end
        S_SER: begin
          mb_r <= r62_r;
          if (n_r > 5'd24 || term_r == 64'd0) begin
            st_r <= S_PRC;
          end else begin
            acc_r <= acc_r + (128'(pprod) << (32 * ((pp_r == 2'd0) ? 0 :
                       (pp_r == 2'd3) ? 2 : 1)));
            if (pp_r == 2'd3) begin
              pp_r <= 2'd0;
              st_r <= S_M0;
            end else begin
              pp_r <= pp_r + 2'd1;
            end
          end
        end
        S_M0: begin
          // Divide the product of term and r by n, one quotient bit per cycle.
          num_r <= {64'd0, acc_r[125:62]};
          rem_r <= '0;
          q_r <= '0;
          i_r <= 7'd63;
          st_r <= S_M1;
        end
        S_M1: begin
          if ({rem_r[62:0], num_r[i_r[5:0]]} >= 64'(n_r)) begin
            rem_r <= {rem_r[62:0], num_r[i_r[5:0]]} - 64'(n_r);
            q_r <= {q_r[62:0], 1'b1};
          end else begin
            rem_r <= {rem_r[62:0], num_r[i_r[5:0]]};
            q_r <= {q_r[62:0], 1'b0};
          end
          if (i_r == 7'd0) begin
            term_r <= {q_r[62:0], ({rem_r[62:0], num_r[0]} >= 64'(n_r))};
            sum_r <= sum_r + {q_r[62:0], ({rem_r[62:0], num_r[0]} >= 64'(n_r))};
            ma_r <= {q_r[62:0], ({rem_r[62:0], num_r[0]} >= 64'(n_r))};
            n_r <= n_r + 5'd1;
            acc_r <= '0;
            st_r <= S_SER;
          end else begin
            i_r <= i_r - 7'd1;
          end
        end
        S_PRC: begin
          if (!($signed(k_r) < -64'sd17) && (ex_w > 64'hFFFF_FFFF)) begin
            sat_r <= 1'b1;
          end
          ma_r <= 64'(cfg.spot);
          mb_r <= ($signed(k_r) < -64'sd17) ? 64'd0 :
                  (ex_w > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : ex_w;
          pp_r <= 2'd0;
          acc_r <= '0;
          st_r <= S_PM0;
        end
        S_PM0: begin
          if (pp_r == 2'd0) begin
            tmp_r <= (mb_r[31:0] * ma_r[31:0] + 64'h8000) >> 16;
            pp_r <= 2'd1;
          end else begin
            pp_r <= 2'd0;
            if (tmp_r > 64'hFFFF_FFFF) begin
              tmp_r <= 64'hFFFF_FFFF;
              sat_r <= 1'b1;
            end
            st_r <= S_PAY;
          end
        end
        S_PAY: begin
          if (ps_add[64]) begin
            psum_r <= '1;
            sat_r <= 1'b1;
          end else begin
            psum_r <= ps_add[63:0];
          end
          if (pcnt_r + PW'(1) >= effp) begin
            ma_r <= ps_add[64] ? '1 : ps_add[63:0];
            mb_r <= 64'(cfg.disc);
            pp_r <= 2'd0;
            acc_r <= '0;
            pcnt_r <= '0;
            st_r <= S_FMUL;
          end else begin
            pcnt_r <= pcnt_r + PW'(1);
            st_r <= S_IDLE;
          end
        end
        S_FMUL: begin
          acc_r <= acc_r + (128'(pprod) << (32 * ((pp_r == 2'd0) ? 0 :
                     (pp_r == 2'd3) ? 2 : 1)));
          pp_r <= pp_r + 2'd1;
          if (pp_r == 2'd3) st_r <= S_FNUM;
        end
        S_FNUM: begin
          num_r <= nm_add;
          rem_r <= '0;
          q_r <= '0;
          big_r <= 1'b0;
          i_r <= 7'd127;
          st_r <= S_DIV;
        end
        S_DIV: begin
          if (rem_sh >= 65'(d_w)) begin
            rem_r <= 64'(rem_sh - 65'(d_w));
            if ({q_sh[63:1], 1'b1} > 64'hFFFF_FFFF) big_r <= 1'b1;
            q_r <= {32'd0, q_sh[31:1], 1'b1};
          end else begin
            rem_r <= rem_sh[63:0];
            if (q_sh > 64'hFFFF_FFFF) big_r <= 1'b1;
            q_r <= {32'd0, q_sh[31:0]};
          end
          num_r <= {num_r[126:0], 1'b0};
          if (i_r == 7'd0) st_r <= S_OUT;
          else i_r <= i_r - 7'd1;
        end
        S_OUT: begin
          if (!out_v_r) begin
            price_out_r <= big_r ? 32'hFFFF_FFFF : q_r[31:0];
            out_sat_r <= sat_r | big_r;
            out_v_r <= 1'b1;
            psum_r <= '0;
            sat_r <= 1'b0;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
